/* sv/particle_pool_update_macros.svh */
// assertion macros shared by the particle pool rtl
// no dependencies
`ifndef PARTICLE_POOL_UPDATE_MACROS_SVH
`define PARTICLE_POOL_UPDATE_MACROS_SVH

// implication checked every clock, quiet during reset
`define PPU_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, quiet during reset
`define PPU_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* sv/ppu_pkg.sv */
// package for the particle pool: widths, kinds, damping constants, states
// no dependencies
package ppu_pkg;

	localparam int PoolDepth = 64;
	localparam int SlotW     = $clog2(PoolDepth);
	localparam int QW        = 20;
	localparam int LifeW     = 15;

	localparam logic [3:0] KIND_FREE   = 4'd0;
	localparam logic [3:0] KIND_SPARK  = 4'd1;
	localparam logic [3:0] KIND_EMBER  = 4'd2;
	localparam logic [3:0] KIND_DEBRIS = 4'd3;
	localparam logic [3:0] KIND_FIRE   = 4'd4;
	localparam logic [3:0] KIND_RING   = 4'd6;
	localparam logic [3:0] KIND_TEXT   = 4'd8;

	localparam logic [16:0] DAMP_SPARK  = 17'd58982;
	localparam logic [16:0] DAMP_EMBER  = 17'd62915;
	localparam logic [16:0] DAMP_DEBRIS = 17'd64225;
	localparam logic [16:0] DAMP_FIRE   = 17'd61604;
	localparam logic [16:0] DAMP_RING   = 17'd60948;
	localparam logic [16:0] DAMP_TEXT   = 17'd62259;
	localparam logic [16:0] DAMP_NONE   = 17'd65536;

	localparam logic OP_SPAWN = 1'b0;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_WRITE,
		ST_RD,
		ST_LOAD,
		ST_PX,
		ST_PY,
		ST_VX,
		ST_VY,
		ST_GR,
		ST_WB,
		ST_OUT,
		ST_TAIL
	} state_t;

	// saturating q11.8 add
	function automatic logic [QW-1:0] sat_add(input logic [QW-1:0] a, input logic [QW-1:0] b);
		logic signed [QW:0] s;
		s = $signed({a[QW-1], a}) + $signed({b[QW-1], b});
		if (s[QW] != s[QW-1])
			return s[QW] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
		return s[QW-1:0];
	endfunction

	function automatic logic [16:0] damp_const(input logic [3:0] k, input logic is_y,
			input logic is_growth);
		logic [16:0] c;
		c = DAMP_NONE;
		case (k)
			KIND_SPARK:  c = is_growth ? DAMP_NONE : DAMP_SPARK;
			KIND_EMBER:  c = is_growth ? DAMP_NONE : DAMP_EMBER;
			KIND_DEBRIS: c = is_growth ? DAMP_NONE : DAMP_DEBRIS;
			KIND_FIRE:   c = is_growth ? DAMP_NONE : DAMP_FIRE;
			KIND_RING:   c = is_growth ? DAMP_RING : DAMP_NONE;
			KIND_TEXT:   c = (is_y && !is_growth) ? DAMP_TEXT : DAMP_NONE;
			default:     c = DAMP_NONE;
		endcase
		return c;
	endfunction

endpackage

/* sv/particle_pool_update.sv */
// particle pool top level: slot memory, round-robin spawn search, tick walker
// depends on ppu_pkg and particle_pool_update_macros.svh
//
// usage: s_axis carries one word per request, operation in tuser (0 spawn,
// 1 tick). a spawn stores the particle in the first free slot at or after the
// round-robin pointer (the pointer slot is recycled when none is free) and
// returns one word with tlast set. a tick walks every slot; each live slot is
// counted down or moved and damped, and each visible one is sent on m_axis,
// the final word of the tick carrying tlast. a tick with nothing visible
// sends no word. one visible word is held back until the walker knows
// whether another one follows, and goes out last after the final slot.
// timing: a spawn reads one slot's live bit per cycle while searching. a tick
// steps one shared adder and one 20x17 multiplier over the position, velocity
// and growth fields of each moving slot; s_axis_tready is low for the whole
// request.
// stall: while m_axis_tready is low and a word waits, the walker holds.
// reset clears the live bits (all slots free) and the pointer at once;
// the other slot fields have no reset and are written by spawn before use.
`include "particle_pool_update_macros.svh"
module particle_pool_update (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// kind[3:0] pos_x[23:4] pos_y[43:24] vel_x[63:44] vel_y[83:64] radius[103:84]
	// growth[123:104] life[138:124] delay[153:139] color[185:154] size[193:186]
	input  logic [199:0] s_axis_tdata,
	// operation
	input  logic         s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// slot[5:0] kind_out[9:6] out_x[29:10] out_y[49:30] out_vel_x[69:50]
	// out_vel_y[89:70] out_radius[109:90] life_left[124:110] life_max[139:125]
	// out_color[171:140] out_size[179:172]
	output logic [183:0] m_axis_tdata,
	output logic         m_axis_tlast
);

	localparam int SW = ppu_pkg::SlotW;
	localparam int QW = ppu_pkg::QW;
	localparam int LW = ppu_pkg::LifeW;

	ppu_pkg::state_t state_q, state_d;

	// valid bits stand in for the kind reset
	logic [ppu_pkg::PoolDepth-1:0] live_q;
	logic [3:0]    mem_kind   [ppu_pkg::PoolDepth];
	logic [QW-1:0] mem_px     [ppu_pkg::PoolDepth];
	logic [QW-1:0] mem_py     [ppu_pkg::PoolDepth];
	logic [QW-1:0] mem_vx     [ppu_pkg::PoolDepth];
	logic [QW-1:0] mem_vy     [ppu_pkg::PoolDepth];
	logic [QW-1:0] mem_rad    [ppu_pkg::PoolDepth];
	logic [QW-1:0] mem_gr     [ppu_pkg::PoolDepth];
	logic [LW-1:0] mem_life   [ppu_pkg::PoolDepth];
	logic [LW-1:0] mem_lmax   [ppu_pkg::PoolDepth];
	logic [LW-1:0] mem_delay  [ppu_pkg::PoolDepth];
	logic [31:0]   mem_color  [ppu_pkg::PoolDepth];
	logic [7:0]    mem_size   [ppu_pkg::PoolDepth];

	logic [SW-1:0] next_q, idx_q, first_q;
	logic [SW:0]   cnt_q;
	logic [199:0]  in_q;

	// working copy of one slot
	logic [3:0]    kind_q;
	logic [QW-1:0] px_q, py_q, vx_q, vy_q, rad_q, gr_q;
	logic [LW-1:0] life_q, lmax_q, delay_q;
	logic [31:0]   color_q;
	logic [7:0]    size_q;

	logic          ovalid_q, olast_q;
	logic [183:0]  odata_q;

	// visible word held back until the next one or the end is known
	logic          pend_q;
	logic [183:0]  pend_data_q;

	logic          in_acc, out_free;
	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign out_free = !ovalid_q || m_axis_tready;
	assign s_axis_tready = (state_q == ppu_pkg::ST_IDLE);
	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = odata_q;
	assign m_axis_tlast  = olast_q;

	// shared multiplier: 20 x 17 signed product, floor by the shift
	logic [QW-1:0]        mul_a;
	logic [16:0]          mul_c;
	logic signed [QW+17:0] mul_p;
	logic [QW-1:0]        mul_r;
	assign mul_p = $signed(mul_a) * $signed({1'b0, mul_c});
	assign mul_r = mul_p[QW+15:16];

	// shared saturating adder
	logic [QW-1:0] add_a, add_b, add_r;
	assign add_r = ppu_pkg::sat_add(add_a, add_b);

	logic moving;
	assign moving = (delay_q == '0);

	always_comb begin
		mul_a = vx_q;
		mul_c = ppu_pkg::damp_const(kind_q, 1'b0, 1'b0);
		add_a = px_q;
		add_b = vx_q;
		case (state_q)
			ppu_pkg::ST_VY: begin
				mul_a = vy_q;
				mul_c = ppu_pkg::damp_const(kind_q, 1'b1, 1'b0);
			end
			ppu_pkg::ST_GR: begin
				mul_a = gr_q;
				mul_c = ppu_pkg::damp_const(kind_q, 1'b0, 1'b1);
				add_a = rad_q;
				add_b = gr_q;
			end
			ppu_pkg::ST_PY: begin
				add_a = py_q;
				add_b = vy_q;
			end
			default: begin
			end
		endcase
	end

	logic slot_live;
	assign slot_live = live_q[idx_q];
	logic last_slot;
	assign last_slot = (cnt_q == (SW+1)'(ppu_pkg::PoolDepth - 1));
	logic visible;
	assign visible = slot_live && (delay_q == '0);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ppu_pkg::ST_IDLE:
				if (in_acc)
					state_d = (s_axis_tuser == ppu_pkg::OP_SPAWN) ?
						ppu_pkg::ST_SEARCH : ppu_pkg::ST_RD;
			ppu_pkg::ST_SEARCH:
				if (!slot_live || last_slot) state_d = ppu_pkg::ST_WRITE;
			ppu_pkg::ST_WRITE:
				if (out_free) state_d = ppu_pkg::ST_IDLE;
			ppu_pkg::ST_RD:
				state_d = slot_live ? ppu_pkg::ST_LOAD : ppu_pkg::ST_OUT;
			ppu_pkg::ST_LOAD: state_d = moving ? ppu_pkg::ST_PX : ppu_pkg::ST_WB;
			ppu_pkg::ST_PX:   state_d = ppu_pkg::ST_PY;
			ppu_pkg::ST_PY:   state_d = ppu_pkg::ST_VX;
			ppu_pkg::ST_VX:   state_d = ppu_pkg::ST_VY;
			ppu_pkg::ST_VY:   state_d = ppu_pkg::ST_GR;
			ppu_pkg::ST_GR:   state_d = ppu_pkg::ST_WB;
			ppu_pkg::ST_WB:   state_d = ppu_pkg::ST_OUT;
			ppu_pkg::ST_OUT:
				if (out_free) state_d = last_slot ? ppu_pkg::ST_TAIL : ppu_pkg::ST_RD;
			ppu_pkg::ST_TAIL:
				if (out_free) state_d = ppu_pkg::ST_IDLE;
			default: state_d = ppu_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ppu_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	function automatic logic [183:0] pack_out(input logic [SW-1:0] s, input logic [3:0] k,
			input logic [QW-1:0] x, input logic [QW-1:0] y, input logic [QW-1:0] vx,
			input logic [QW-1:0] vy, input logic [QW-1:0] r, input logic [LW-1:0] l,
			input logic [LW-1:0] lm, input logic [31:0] c, input logic [7:0] sz);
		return {4'd0, sz, c, lm, l, r, vy, vx, y, x, k, s};
	endfunction

	// output register load
	logic          o_load, o_last_d;
	logic [183:0]  o_data_d;
	always_comb begin
		o_load   = 1'b0;
		o_last_d = 1'b0;
		o_data_d = pend_data_q;
		case (state_q)
			ppu_pkg::ST_WRITE: begin
				o_load   = out_free;
				o_last_d = 1'b1;
				o_data_d = pack_out(idx_q, in_q[3:0], in_q[23:4], in_q[43:24],
					in_q[63:44], in_q[83:64], in_q[103:84], in_q[138:124],
					in_q[138:124], in_q[185:154], in_q[193:186]);
			end
			ppu_pkg::ST_OUT: o_load = out_free && visible && pend_q;
			ppu_pkg::ST_TAIL: begin
				o_load   = out_free && pend_q;
				o_last_d = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
			olast_q  <= 1'b0;
			odata_q  <= '0;
		end else if (o_load) begin
			ovalid_q <= 1'b1;
			olast_q  <= o_last_d;
			odata_q  <= o_data_d;
		end else if (m_axis_tready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q      <= '0;
			next_q      <= '0;
			pend_q      <= 1'b0;
			pend_data_q <= '0;
			in_q        <= '0;
			idx_q       <= '0;
			cnt_q       <= '0;
			first_q     <= '0;
		end else begin
			case (state_q)
				ppu_pkg::ST_IDLE: begin
					if (in_acc) begin
						in_q  <= s_axis_tdata;
						cnt_q <= '0;
						if (s_axis_tuser == ppu_pkg::OP_SPAWN) begin
							idx_q   <= next_q;
							first_q <= next_q;
						end else begin
							idx_q <= '0;
						end
						pend_q <= 1'b0;
					end
				end
				ppu_pkg::ST_SEARCH: begin
					if (!slot_live || last_slot) begin
						if (slot_live) idx_q <= first_q;
					end else begin
						idx_q <= SW'((32'(idx_q) + 1) % ppu_pkg::PoolDepth);
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ppu_pkg::ST_WRITE: begin
					if (out_free) begin
						live_q[idx_q] <= (in_q[3:0] != ppu_pkg::KIND_FREE);
						next_q <= SW'((32'(idx_q) + 1) % ppu_pkg::PoolDepth);
					end
				end
				ppu_pkg::ST_WB: begin
					if (moving && life_q <= LW'(1)) live_q[idx_q] <= 1'b0;
				end
				ppu_pkg::ST_OUT: begin
					if (out_free) begin
						if (visible) begin
							pend_q      <= 1'b1;
							pend_data_q <= pack_out(idx_q, kind_q, px_q, py_q, vx_q, vy_q,
								rad_q, life_q, lmax_q, color_q, size_q);
						end
						if (!last_slot) begin
							idx_q <= SW'((32'(idx_q) + 1) % ppu_pkg::PoolDepth);
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				ppu_pkg::ST_TAIL: begin
					if (out_free) pend_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	// slot memory and working copy: read, step through the fields, write back
	always_ff @(posedge clk) begin
		if (state_q == ppu_pkg::ST_RD) begin
			kind_q  <= mem_kind[idx_q];
			px_q    <= mem_px[idx_q];
			py_q    <= mem_py[idx_q];
			vx_q    <= mem_vx[idx_q];
			vy_q    <= mem_vy[idx_q];
			rad_q   <= mem_rad[idx_q];
			gr_q    <= mem_gr[idx_q];
			life_q  <= mem_life[idx_q];
			lmax_q  <= mem_lmax[idx_q];
			delay_q <= mem_delay[idx_q];
			color_q <= mem_color[idx_q];
			size_q  <= mem_size[idx_q];
		end
		if (state_q == ppu_pkg::ST_PX) px_q <= add_r;
		if (state_q == ppu_pkg::ST_PY) py_q <= add_r;
		if (state_q == ppu_pkg::ST_VX) vx_q <= mul_r;
		if (state_q == ppu_pkg::ST_VY) vy_q <= mul_r;
		if (state_q == ppu_pkg::ST_GR && kind_q == ppu_pkg::KIND_RING) begin
			rad_q <= add_r;
			gr_q  <= mul_r;
		end
		if (state_q == ppu_pkg::ST_WB) begin
			if (moving) begin
				life_q <= (life_q <= LW'(1)) ? '0 : life_q - 1'b1;
			end else begin
				delay_q <= delay_q - 1'b1;
			end
		end
		if (state_q == ppu_pkg::ST_WRITE && out_free) begin
			mem_kind[idx_q]  <= in_q[3:0];
			mem_px[idx_q]    <= in_q[23:4];
			mem_py[idx_q]    <= in_q[43:24];
			mem_vx[idx_q]    <= in_q[63:44];
			mem_vy[idx_q]    <= in_q[83:64];
			mem_rad[idx_q]   <= in_q[103:84];
			mem_gr[idx_q]    <= in_q[123:104];
			mem_life[idx_q]  <= in_q[138:124];
			mem_lmax[idx_q]  <= in_q[138:124];
			mem_delay[idx_q] <= in_q[153:139];
			mem_color[idx_q] <= in_q[185:154];
			mem_size[idx_q]  <= in_q[193:186];
		end
		if (state_q == ppu_pkg::ST_OUT && out_free && slot_live) begin
			mem_px[idx_q]    <= px_q;
			mem_py[idx_q]    <= py_q;
			mem_vx[idx_q]    <= vx_q;
			mem_vy[idx_q]    <= vy_q;
			mem_rad[idx_q]   <= rad_q;
			mem_gr[idx_q]    <= gr_q;
			mem_life[idx_q]  <= life_q;
			mem_delay[idx_q] <= delay_q;
		end
	end

	`PPU_ASSERT_IMP(a_ready_idle, s_axis_tready, !ovalid_q || state_q == ppu_pkg::ST_IDLE)
	`PPU_ASSERT_NEXT(a_spawn_last, state_q == ppu_pkg::ST_WRITE && out_free, ovalid_q && olast_q)
	`PPU_ASSERT_NEXT(a_out_hold, ovalid_q && !m_axis_tready, ovalid_q && $stable(odata_q))

endmodule

/* bench/tb_particle_pool_update.sv */
// testbench for particle_pool_update: random and directed spawn/tick traffic
// checked against a behavioral pool model; depends on ppu_pkg and the rtl
module tb_particle_pool_update;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic        op;
		logic [3:0]  kind;
		logic [19:0] px, py, vx, vy, rad, grow;
		logic [14:0] life, delay;
		logic [31:0] color;
		logic [7:0]  size;
	} req_t;

	typedef struct packed {
		logic [5:0]  slot;
		logic [3:0]  kind;
		logic [19:0] x, y, vx, vy, rad;
		logic [14:0] life, lmax;
		logic [31:0] color;
		logic [7:0]  size;
		logic        last;
	} word_t;

	logic clk = 0, arst_n = 0;
	logic s_axis_tvalid = 0, s_axis_tuser = 0, m_axis_tready = 0;
	logic [199:0] s_axis_tdata = '0;
	logic s_axis_tready, m_axis_tvalid, m_axis_tlast;
	logic [183:0] m_axis_tdata;

	particle_pool_update dut (.*);

	initial forever #2 clk = ~clk;

	// particle store mirrored from the block
	logic [3:0]  p_kind [ppu_pkg::PoolDepth];
	logic signed [19:0] p_px [ppu_pkg::PoolDepth], p_py [ppu_pkg::PoolDepth];
	logic signed [19:0] p_vx [ppu_pkg::PoolDepth], p_vy [ppu_pkg::PoolDepth];
	logic signed [19:0] p_rad [ppu_pkg::PoolDepth], p_grow [ppu_pkg::PoolDepth];
	logic [14:0] p_life [ppu_pkg::PoolDepth], p_lmax [ppu_pkg::PoolDepth];
	logic [14:0] p_delay [ppu_pkg::PoolDepth];
	logic [31:0] p_color [ppu_pkg::PoolDepth];
	logic [7:0]  p_size [ppu_pkg::PoolDepth];
	logic [5:0]  rr_ptr;

	req_t  pending_reqs[$];
	word_t expected_words[$];
	int errors = 0, words_seen = 0;
	bit quiet = 1, hold_off = 0;

	function automatic logic signed [19:0] sat20(longint v);
		if (v > 524287) return 20'sd524287;
		if (v < -524288) return -20'sd524288;
		return v[19:0];
	endfunction

	function automatic logic signed [19:0] damp(logic signed [19:0] v, longint c);
		longint p;
		p = longint'(v) * c;
		return 20'(p >>> 16);  // arithmetic shift floors
	endfunction

	function automatic word_t slot_word(int i, bit last);
		word_t w;
		w = '{i[5:0], p_kind[i], p_px[i], p_py[i], p_vx[i], p_vy[i], p_rad[i],
			p_life[i], p_lmax[i], p_color[i], p_size[i], last};
		return w;
	endfunction

	task automatic predict_pool(req_t r);
		int pick, i, n, lasti;
		longint c;
		if (r.op == ppu_pkg::OP_SPAWN) begin
			pick = rr_ptr;
			for (n = 0; n < ppu_pkg::PoolDepth; n++) begin
				i = (rr_ptr + n) % ppu_pkg::PoolDepth;
				if (p_kind[i] == ppu_pkg::KIND_FREE) begin
					pick = i;
					break;
				end
			end
			rr_ptr = 6'(pick + 1);
			p_kind[pick] = r.kind; p_px[pick] = r.px; p_py[pick] = r.py;
			p_vx[pick] = r.vx; p_vy[pick] = r.vy; p_rad[pick] = r.rad;
			p_grow[pick] = r.grow; p_life[pick] = r.life; p_lmax[pick] = r.life;
			p_delay[pick] = r.delay; p_color[pick] = r.color; p_size[pick] = r.size;
			expected_words.push_back(slot_word(pick, 1));
		end else begin
			lasti = -1;
			for (i = 0; i < ppu_pkg::PoolDepth; i++) begin
				if (p_kind[i] == ppu_pkg::KIND_FREE) continue;
				if (p_delay[i] != 0) p_delay[i]--;
				else begin
					p_px[i] = sat20(longint'(p_px[i]) + p_vx[i]);
					p_py[i] = sat20(longint'(p_py[i]) + p_vy[i]);
					c = 0;
					case (p_kind[i])
						ppu_pkg::KIND_SPARK: c = ppu_pkg::DAMP_SPARK;
						ppu_pkg::KIND_EMBER: c = ppu_pkg::DAMP_EMBER;
						ppu_pkg::KIND_DEBRIS: c = ppu_pkg::DAMP_DEBRIS;
						ppu_pkg::KIND_FIRE: c = ppu_pkg::DAMP_FIRE;
						ppu_pkg::KIND_RING: begin
							p_rad[i] = sat20(longint'(p_rad[i]) + p_grow[i]);
							p_grow[i] = damp(p_grow[i], ppu_pkg::DAMP_RING);
						end
						ppu_pkg::KIND_TEXT: p_vy[i] = damp(p_vy[i], ppu_pkg::DAMP_TEXT);
						default: ;
					endcase
					if (c != 0) begin
						p_vx[i] = damp(p_vx[i], c);
						p_vy[i] = damp(p_vy[i], c);
					end
					if (p_life[i] <= 1) begin
						p_life[i] = 0;
						p_kind[i] = ppu_pkg::KIND_FREE;
					end else p_life[i]--;
				end
				if (p_kind[i] != ppu_pkg::KIND_FREE && p_delay[i] == 0) begin
					expected_words.push_back(slot_word(i, 0));
					lasti = i;
				end
			end
			if (lasti >= 0) expected_words[$].last = 1;
		end
	endtask

	task automatic report(string what, word_t got, word_t want);
		errors++;
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
	endtask

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) predict_pool(pending_reqs.pop_front());
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_reqs.size() > 0 && (quiet || $urandom_range(99) >= 9)) begin
					s_axis_tvalid <= 1;
					{s_axis_tuser, s_axis_tdata} <= {pending_reqs[0].op, 6'b0,
						pending_reqs[0].size, pending_reqs[0].color, pending_reqs[0].delay,
						pending_reqs[0].life, pending_reqs[0].grow, pending_reqs[0].rad,
						pending_reqs[0].vy, pending_reqs[0].vx, pending_reqs[0].py,
						pending_reqs[0].px, pending_reqs[0].kind};
				end else s_axis_tvalid <= 0;
			end
		end
	end

	// monitor and receiver
	always @(posedge clk) begin
		word_t got, want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.slot  = m_axis_tdata[5:0];
				got.kind  = m_axis_tdata[9:6];
				got.x     = m_axis_tdata[29:10];
				got.y     = m_axis_tdata[49:30];
				got.vx    = m_axis_tdata[69:50];
				got.vy    = m_axis_tdata[89:70];
				got.rad   = m_axis_tdata[109:90];
				got.life  = m_axis_tdata[124:110];
				got.lmax  = m_axis_tdata[139:125];
				got.color = m_axis_tdata[171:140];
				got.size  = m_axis_tdata[179:172];
				got.last  = m_axis_tlast;
				words_seen++;
				if (expected_words.size() == 0) report("unexpected word", got, got);
				else begin
					want = expected_words.pop_front();
					if (got.slot != want.slot) report("slot", got, want);
					if (got.kind != want.kind) report("kind", got, want);
					if (got.x != want.x || got.y != want.y) report("position", got, want);
					if (got.vx != want.vx || got.vy != want.vy) report("velocity", got, want);
					if (got.rad != want.rad) report("radius", got, want);
					if (got.life != want.life || got.lmax != want.lmax) report("life", got, want);
					if (got.color != want.color || got.size != want.size)
						report("color/size", got, want);
					if (got.last != want.last) report("last", got, want);
				end
			end
			m_axis_tready <= !hold_off && (quiet || $urandom_range(99) >= 9);
		end
	end

	function automatic req_t rand_spawn(logic [3:0] k);
		req_t r;
		r.op = ppu_pkg::OP_SPAWN;
		r.kind = k;
		r.px = 20'($urandom); r.py = 20'($urandom);
		r.vx = $urandom_range(1) ? 20'($urandom) : 20'($urandom_range(2047) - 1024);
		r.vy = $urandom_range(1) ? 20'($urandom) : 20'($urandom_range(2047) - 1024);
		r.rad = 20'($urandom); r.grow = 20'($urandom);
		r.life = $urandom_range(3) == 0 ? 15'($urandom) : 15'($urandom_range(12));
		r.delay = $urandom_range(3) == 0 ? 15'($urandom_range(4)) : 15'd0;
		if ($urandom_range(15) == 0) r.delay = 15'($urandom);
		r.color = $urandom; r.size = 8'($urandom);
		return r;
	endfunction

	function automatic req_t tick_req();
		req_t r;
		r = '0;
		r.op = ~ppu_pkg::OP_SPAWN;
		r.px = 20'($urandom);  // ignored by a tick
		return r;
	endfunction

	task automatic wait_drained();
		while (pending_reqs.size() != 0 || s_axis_tvalid || expected_words.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		req_t r;
		int k, n, cnt;
		for (k = 0; k < ppu_pkg::PoolDepth; k++) p_kind[k] = ppu_pkg::KIND_FREE;
		rr_ptr = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		// directed: every kind, field extremes, kind zero, life zero
		for (k = 0; k < 16; k++) begin
			r = rand_spawn(k[3:0]);
			r.life = (k == 3) ? 15'd0 : (k == 4 ? 15'h7FFF : 15'd5);
			r.delay = (k == 5) ? 15'd2 : 15'd0;
			if (k == 1) begin
				r.px = 20'h7FFFF; r.vx = 20'h7FFFF; r.py = 20'h80000; r.vy = 20'h80000;
			end
			if (k == 6) begin
				r.rad = 20'h7FFF0; r.grow = 20'h00100;
			end
			if (k == 7) begin
				r.color = '1; r.size = '1;
			end
			pending_reqs.push_back(r);
		end
		repeat (4) pending_reqs.push_back(tick_req());
		wait_drained();
		// recycle when pool full: fill all slots with long-lived particles
		for (k = 0; k < ppu_pkg::PoolDepth + 3; k++) begin
			r = rand_spawn(4'($urandom_range(1, 8)));
			r.life = 15'd200;
			pending_reqs.push_back(r);
		end
		pending_reqs.push_back(tick_req());
		// long receiver hold-off while items keep coming
		hold_off = 1;
		cnt = 0;
		while (cnt < 600) begin
			@(posedge clk);
			cnt++;
		end
		hold_off = 0;
		wait_drained();
		// random phase, first part with no idling, then idling
		for (n = 0; n < 232; n++) begin
			if (n == 60) begin
				wait_drained();
				quiet = 0;
			end
			if ($urandom_range(3) == 0) r = tick_req();
			else r = rand_spawn($urandom_range(15) == 0 ? 4'($urandom) :
				4'($urandom_range(1, 8)));
			pending_reqs.push_back(r);
			if (n % 40 == 39) wait_drained();
			while (pending_reqs.size() > 4) @(posedge clk);
		end
		wait_drained();
		repeat (200) @(posedge clk);
		$display("covered spawns of all kinds, pool recycling, saturation, delays,");
		$display("long output stalls; %0d result words checked", words_seen);
		if (errors == 0 && expected_words.size() == 0) $display("Simulation PASSED");
		else $display("Simulation FAILED");
		$finish;
	end

	initial begin
		#20ms;
		$display("Simulation FAILED");
		$finish;
	end
endmodule

/* particle_pool_update.f */
+incdir+sv
sv/ppu_pkg.sv
sv/particle_pool_update.sv
bench/tb_particle_pool_update.sv
